// File: rtl/peak_hold_decay_envelope_defines.svh
// Assertion macros for the checker file of the envelope block.
// Each macro samples on clock; all but the reset check are disabled in reset.
`ifndef PEAK_HOLD_DECAY_ENVELOPE_DEFINES_SVH
`define PEAK_HOLD_DECAY_ENVELOPE_DEFINES_SVH

// Same-cycle implication.
`define PHDE_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PHDE_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that stays live during reset.
`define PHDE_CHECK_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/phde_pkg.sv
`default_nettype none

package phde_pkg;

   // Field widths
   localparam int MIC_W      = 16;
   localparam int MS_W       = 8;
   localparam int SEC_W      = 20;
   localparam int HUE_W      = 24;
   localparam int BRT_W      = 16;
   localparam int STEP_W     = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 16;

   // Divider for the smoothing divisor
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 16;

   // Sequencer
   localparam int CNT_W = 8;
   localparam int UPC_W = 4;

   typedef logic [UPC_W-1:0]      upc_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   localparam csr_addr_type CSR_SMOOTHING_DIVISOR = 4'd0;
   localparam csr_addr_type CSR_BASE_BRIGHTNESS   = 4'd1;

   localparam logic [CSR_DATA_W-1:0] DIVISOR_RESET = 16'h0000;
   localparam logic [CSR_DATA_W-1:0] BASE_RESET    = 16'h8000;

   // One in Q0.16, one bit wider than a brightness value.
   localparam logic [BRT_W:0] Q16_ONE = 17'h10000;

   // Target brightness products
   localparam int TGT_P1_W = 2 * MIC_W;
   localparam int TGT_P2_W = TGT_P1_W + BRT_W + 1;

   // Hue release step: x + floor((t - x + 50) / 101). The division is an exact
   // reciprocal multiply for operands below 2^25.
   localparam int HUE_N_W       = HUE_W + 2;
   localparam int HUE_A_W       = HUE_W + 1;
   localparam int HUE_RECIP_W   = 26;
   localparam int HUE_PROD_W    = HUE_A_W + HUE_RECIP_W;
   localparam int HUE_SHIFT     = 32;
   localparam int HUE_Q_W       = HUE_PROD_W - HUE_SHIFT;
   localparam int HUE_ROUND     = 50;
   localparam int HUE_BIAS      = 100;
   localparam logic [HUE_RECIP_W-1:0] HUE_RECIP = 26'd42524429;

   // Brightness release step: x + floor((t - x + 100) / 201), operands below 2^17.
   localparam int BRT_N_W       = BRT_W + 2;
   localparam int BRT_A_W       = BRT_W + 1;
   localparam int BRT_RECIP_W   = 18;
   localparam int BRT_PROD_W    = BRT_A_W + BRT_RECIP_W;
   localparam int BRT_SHIFT     = 25;
   localparam int BRT_Q_W       = BRT_PROD_W - BRT_SHIFT;
   localparam int BRT_ROUND     = 100;
   localparam int BRT_BIAS      = 200;
   localparam logic [BRT_RECIP_W-1:0] BRT_RECIP = 18'd166938;

   // Hue step products
   localparam int HUE_SCALE_W = 7;
   localparam logic [HUE_SCALE_W-1:0] HUE_SCALE = 7'd100;
   localparam int HUE_P1_W    = HUE_W + SEC_W;
   localparam int HUE_P2_W    = HUE_P1_W + HUE_SCALE_W;

   typedef struct packed {
      logic [MIC_W-1:0] mic_level;
      logic [MS_W-1:0]  ms_elapsed;
      logic [SEC_W-1:0] seconds_elapsed;
   } req_item_type;

   typedef struct packed {
      logic [BRT_W-1:0]  brightness_out;
      logic [MIC_W-1:0]  mic_level_out;
      logic [STEP_W-1:0] hue_step;
   } rsp_item_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_LOAD_DIV,
      CNT_LOAD_STEPS,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_DIV_ZERO,
      COND_STEPS_ZERO,
      COND_CNT_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic       accept;
      cnt_op_type cnt_op;
      logic       div_load;
      logic       div_step;
      logic       madd_bypass;
      logic       madd_wb;
      logic       tgt_mul1;
      logic       tgt_mul2;
      logic       tgt_sum;
      logic       decay;
      logic       attack;
      logic       hue_mul1;
      logic       hue_mul2;
      logic       out_load;
      cond_type   cond;
      upc_type    target;
   } uword_type;

   typedef struct packed {
      logic             div_zero;
      logic [CNT_W-1:0] steps;
      logic             out_busy;
   } status_type;

   // Microprogram addresses
   localparam upc_type UPC_IDLE      = 4'd0;
   localparam upc_type UPC_SETUP     = 4'd1;
   localparam upc_type UPC_DIV       = 4'd2;
   localparam upc_type UPC_DIV_WB    = 4'd3;
   localparam upc_type UPC_TARGET    = 4'd4;
   localparam upc_type UPC_DECAY     = 4'd5;
   localparam upc_type UPC_ATTACK    = 4'd6;
   localparam upc_type UPC_HUE_MUL   = 4'd7;
   localparam upc_type UPC_HUE_SCALE = 4'd8;
   localparam upc_type UPC_EMIT      = 4'd9;

   function automatic uword_type ucode(input upc_type upc);
      uword_type w;
      w        = '0;
      w.cnt_op = CNT_HOLD;
      w.cond   = COND_NONE;
      w.target = UPC_IDLE;
      case (upc)
         UPC_IDLE: begin
            w.accept = 1'b1;
            w.cond   = COND_NO_REQ;
            w.target = UPC_IDLE;
         end
         UPC_SETUP: begin
            w.div_load    = 1'b1;
            w.madd_bypass = 1'b1;
            w.tgt_mul1    = 1'b1;
            w.cnt_op      = CNT_LOAD_DIV;
            w.cond        = COND_DIV_ZERO;
            w.target      = UPC_DIV_WB;
         end
         UPC_DIV: begin
            w.div_step = 1'b1;
            w.cnt_op   = CNT_DEC;
            w.cond     = COND_CNT_MORE;
            w.target   = UPC_DIV;
         end
         UPC_DIV_WB: begin
            w.madd_wb  = 1'b1;
            w.tgt_mul2 = 1'b1;
         end
         UPC_TARGET: begin
            w.tgt_sum = 1'b1;
            w.cnt_op  = CNT_LOAD_STEPS;
            w.cond    = COND_STEPS_ZERO;
            w.target  = UPC_ATTACK;
         end
         UPC_DECAY: begin
            w.decay  = 1'b1;
            w.cnt_op = CNT_DEC;
            w.cond   = COND_CNT_MORE;
            w.target = UPC_DECAY;
         end
         UPC_ATTACK: begin
            w.attack = 1'b1;
         end
         UPC_HUE_MUL: begin
            w.hue_mul1 = 1'b1;
         end
         UPC_HUE_SCALE: begin
            w.hue_mul2 = 1'b1;
            w.cond     = COND_OUT_BUSY;
            w.target   = UPC_HUE_SCALE;
         end
         UPC_EMIT: begin
            w.out_load = 1'b1;
            w.cond     = COND_ALWAYS;
            w.target   = UPC_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = UPC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: rtl/peak_hold_decay_envelope.sv
// Channel  Dir  Handshake          Word
// req      in   req_valid/stall    req_item_type (mic level, ms elapsed, seconds)
// rsp      out  rsp_valid/stall    rsp_item_type (brightness, mic level, hue step)
// csr      in   csr_valid/ready    csr_index, csr_wdata (16 bit)
//
// One word at a time. A word goes through the restoring divider, which is
// skipped when the smoothing divisor is zero, and then the decay loop, one
// release step of both envelopes per cycle, steps = min(ms_elapsed,
// MAX_DECAY_STEPS) times.
// Reset is synchronous; it clears the sequencer and the envelopes and sets the control registers to their reset values.
// A finished word waits in the result register while the next word is taken;
// the sequencer holds before writing a result only while rsp_stall holds one.
`default_nettype none

module peak_hold_decay_envelope
   import phde_pkg::*;
#(
   parameter int MAX_DECAY_STEPS = 255,
   parameter int FRAC_BITS       = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_item_type          req_data,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_item_type               rsp_data,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire csr_addr_type          csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   uword_type             uword;
   status_type            status;
   logic [DIV_NUM_W-1:0]  div_num, quot;
   logic [DIV_DEN_W-1:0]  div_den;

   assign csr_ready = 1'b1;
   // The input stays closed during reset so that no word is taken and dropped.
   assign req_stall = reset | !uword.accept;

   phde_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .uword     (uword)
   );

   phde_divider u_divider (
      .clock (clock),
      .uword (uword),
      .num   (div_num),
      .den   (div_den),
      .quot  (quot)
   );

   phde_datapath #(
      .MAX_DECAY_STEPS (MAX_DECAY_STEPS),
      .FRAC_BITS       (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .uword     (uword),
      .req_valid (req_valid),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .quot      (quot),
      .div_num   (div_num),
      .div_den   (div_den),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/phde_sequencer.sv
`default_nettype none

module phde_sequencer
   import phde_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire status_type status,
   output uword_type       uword
);

   upc_type          upc_ff, upc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             jump;

   assign uword = ucode(upc_ff);

   always_comb begin
      case (uword.cond)
         COND_NONE:       jump = 1'b0;
         COND_ALWAYS:     jump = 1'b1;
         COND_NO_REQ:     jump = !req_valid;
         COND_DIV_ZERO:   jump = status.div_zero;
         COND_STEPS_ZERO: jump = (status.steps == '0);
         COND_CNT_MORE:   jump = (cnt_ff > CNT_W'(1));
         COND_OUT_BUSY:   jump = status.out_busy;
         default:         jump = 1'b0;
      endcase

      upc_in = jump ? uword.target : upc_ff + upc_type'(1);

      case (uword.cnt_op)
         CNT_HOLD:       cnt_in = cnt_ff;
         CNT_LOAD_DIV:   cnt_in = CNT_W'(DIV_NUM_W);
         CNT_LOAD_STEPS: cnt_in = status.steps;
         CNT_DEC:        cnt_in = cnt_ff - CNT_W'(1);
         default:        cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_IDLE;
         cnt_ff <= '0;
      end else begin
         upc_ff <= upc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/phde_divider.sv
`default_nettype none

module phde_divider
   import phde_pkg::*;
(
   input  wire logic                 clock,
   input  wire uword_type            uword,
   input  wire logic [DIV_NUM_W-1:0] num,
   input  wire logic [DIV_DEN_W-1:0] den,
   output logic      [DIV_NUM_W-1:0] quot
);

   // Restoring division, one quotient bit per step. The quotient shifts in
   // from the bottom while the numerator shifts out of the top.
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W:0]   shifted;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, quot_ff[DIV_NUM_W-1]};
      fits    = (shifted >= {1'b0, den});
      rem_in  = fits ? DIV_DEN_W'(shifted - {1'b0, den}) : shifted[DIV_DEN_W-1:0];
      quot_in = {quot_ff[DIV_NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (uword.div_load) begin
         rem_ff  <= '0;
         quot_ff <= num;
      end else if (uword.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

// File: rtl/phde_datapath.sv
`default_nettype none

module phde_datapath
   import phde_pkg::*;
#(
   parameter int MAX_DECAY_STEPS = 255,
   parameter int FRAC_BITS       = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire uword_type             uword,
   input  wire logic                  req_valid,
   input  wire req_item_type          req_data,
   input  wire logic                  csr_write,
   input  wire csr_addr_type          csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [DIV_NUM_W-1:0]  quot,
   output logic      [DIV_NUM_W-1:0]  div_num,
   output logic      [DIV_DEN_W-1:0]  div_den,
   output status_type                 status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_item_type               rsp_data
);

   localparam int NUM_SHIFT = FRAC_BITS - 8;
   localparam int BYP_W     = MIC_W + FRAC_BITS;

   req_item_type          req_ff;
   logic [CSR_DATA_W-1:0] divisor_ff, base_ff;
   logic [HUE_W-1:0]      madd_ff, hue_ff, hue_in;
   logic [BRT_W-1:0]      target_ff, bright_ff, bright_in;
   logic [TGT_P1_W-1:0]   tgt_p1_ff;
   logic [TGT_P2_W-1:0]   tgt_p2_ff;
   logic [HUE_P1_W-1:0]   hue_p1_ff;
   logic [HUE_P2_W-1:0]   hue_p2_ff;
   rsp_item_type          rsp_ff;
   logic                  rsp_valid_ff;

   logic [BYP_W-1:0]      byp_wide;
   logic [HUE_W-1:0]      madd_sat;
   logic [BRT_W:0]        headroom;
   logic [BRT_W+1:0]      tgt_sum;
   logic [BRT_W-1:0]      target_sat;
   logic [CNT_W-1:0]      steps;

   logic [HUE_N_W-1:0]    hue_n, hue_a_wide;
   logic [HUE_PROD_W-1:0] hue_prod;
   logic [HUE_Q_W-1:0]    hue_q;
   logic [HUE_W-1:0]      hue_dec;

   logic [BRT_N_W-1:0]    brt_n, brt_a_wide;
   logic [BRT_PROD_W-1:0] brt_prod;
   logic [BRT_Q_W-1:0]    brt_q;
   logic [BRT_W-1:0]      brt_dec;

   logic [HUE_P2_W-1:0]   step_wide;
   logic [STEP_W-1:0]     step_sat;

   always_comb begin
      // With a zero divisor the mic level is just moved to the hue format.
      byp_wide = (BYP_W'(req_ff.mic_level) << FRAC_BITS) >> MIC_W;
      div_num  = DIV_NUM_W'(req_ff.mic_level) << NUM_SHIFT;
      div_den  = divisor_ff;
      madd_sat = (|quot[DIV_NUM_W-1:HUE_W]) ? '1 : quot[HUE_W-1:0];

      headroom   = Q16_ONE - {1'b0, base_ff};
      tgt_sum    = (BRT_W+2)'(base_ff) + (BRT_W+2)'(tgt_p2_ff[TGT_P2_W-1:2*BRT_W]);
      target_sat = (|tgt_sum[BRT_W+1:BRT_W]) ? '1 : tgt_sum[BRT_W-1:0];

      steps = (int'(req_ff.ms_elapsed) > MAX_DECAY_STEPS) ?
              CNT_W'(MAX_DECAY_STEPS) : req_ff.ms_elapsed;

      // Release steps, both envelopes at once. The top bit of the difference
      // is its sign; a negative one is floored by adding the divisor less one.
      hue_n      = {2'b00, madd_ff} - {2'b00, hue_ff} + HUE_N_W'(HUE_ROUND);
      hue_a_wide = hue_n[HUE_N_W-1] ? (HUE_N_W'(HUE_BIAS) - hue_n) : hue_n;
      hue_prod   = HUE_PROD_W'(hue_a_wide[HUE_A_W-1:0]) * HUE_PROD_W'(HUE_RECIP);
      hue_q      = hue_prod[HUE_PROD_W-1:HUE_SHIFT];
      hue_dec    = hue_n[HUE_N_W-1] ? (hue_ff - HUE_W'(hue_q)) : (hue_ff + HUE_W'(hue_q));

      brt_n      = {2'b00, target_ff} - {2'b00, bright_ff} + BRT_N_W'(BRT_ROUND);
      brt_a_wide = brt_n[BRT_N_W-1] ? (BRT_N_W'(BRT_BIAS) - brt_n) : brt_n;
      brt_prod   = BRT_PROD_W'(brt_a_wide[BRT_A_W-1:0]) * BRT_PROD_W'(BRT_RECIP);
      brt_q      = brt_prod[BRT_PROD_W-1:BRT_SHIFT];
      brt_dec    = brt_n[BRT_N_W-1] ? (bright_ff - BRT_W'(brt_q)) :
                   (bright_ff + BRT_W'(brt_q));

      hue_in    = hue_ff;
      bright_in = bright_ff;
      if (uword.decay) begin
         hue_in    = hue_dec;
         bright_in = brt_dec;
      end else if (uword.attack) begin
         hue_in    = (madd_ff > hue_ff) ? madd_ff : hue_ff;
         bright_in = (target_ff > bright_ff) ? target_ff : bright_ff;
      end

      step_wide = hue_p2_ff >> FRAC_BITS;
      step_sat  = (|step_wide[HUE_P2_W-1:STEP_W]) ? '1 : step_wide[STEP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff   <= DIVISOR_RESET;
         base_ff      <= BASE_RESET;
         hue_ff       <= '0;
         bright_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SMOOTHING_DIVISOR: divisor_ff <= csr_wdata;
               CSR_BASE_BRIGHTNESS:   base_ff    <= csr_wdata;
               default:               ;
            endcase
         end
         hue_ff    <= hue_in;
         bright_ff <= bright_in;
         if (uword.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (uword.accept && req_valid) begin
         req_ff <= req_data;
      end
      if (uword.madd_bypass) begin
         madd_ff <= byp_wide[HUE_W-1:0];
      end else if (uword.madd_wb && divisor_ff != '0) begin
         madd_ff <= madd_sat;
      end
      if (uword.tgt_mul1) begin
         tgt_p1_ff <= TGT_P1_W'(req_ff.mic_level) * TGT_P1_W'(base_ff);
      end
      if (uword.tgt_mul2) begin
         tgt_p2_ff <= TGT_P2_W'(tgt_p1_ff) * TGT_P2_W'(headroom);
      end
      if (uword.tgt_sum) begin
         target_ff <= target_sat;
      end
      if (uword.hue_mul1) begin
         hue_p1_ff <= HUE_P1_W'(hue_ff) * HUE_P1_W'(req_ff.seconds_elapsed);
      end
      if (uword.hue_mul2) begin
         hue_p2_ff <= HUE_P2_W'(hue_p1_ff) * HUE_P2_W'(HUE_SCALE);
      end
      if (uword.out_load) begin
         rsp_ff.brightness_out <= bright_ff;
         rsp_ff.mic_level_out  <= req_ff.mic_level;
         rsp_ff.hue_step       <= step_sat;
      end
   end

   assign status.div_zero = (divisor_ff == '0);
   assign status.steps    = steps;
   assign status.out_busy = rsp_valid_ff & rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/phde_checker.sv
`default_nettype none
`include "peak_hold_decay_envelope_defines.svh"

module phde_checker
   import phde_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_item_type rsp_data
);

   `PHDE_CHECK_RESET(a_reset_empty, reset, !rsp_valid, "result valid right after reset")

   // The sequencer leaves the idle word after an accept, so the input closes right after it.
   `PHDE_CHECK_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "input open after accept")

   // A new result is written on the step that returns to the idle word.
   `PHDE_CHECK(a_result_then_idle, $rose(rsp_valid), !req_stall, "new result while input closed")

   `PHDE_CHECK_NEXT(a_result_held, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind peak_hold_decay_envelope phde_checker u_phde_checker (.*);

`default_nettype wire

// File: tb/peak_hold_decay_envelope_tb.sv
`timescale 1ns / 100ps

module peak_hold_decay_envelope_tb;
   import phde_pkg::*;

   localparam int DECAY_CAP = 255;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_item_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_addr_type          csr_index = CSR_SMOOTHING_DIVISOR;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predicted block state and register copies.
   logic [HUE_W-1:0]      hue_env  = '0;
   logic [BRT_W-1:0]      brt_env  = '0;
   logic [CSR_DATA_W-1:0] div_q88  = DIVISOR_RESET;
   logic [CSR_DATA_W-1:0] base_q16 = BASE_RESET;

   req_item_type frames_to_send[$];
   rsp_item_type envelope_out_q[$];
   int unsigned  frames_queued   = 0;
   int unsigned  frames_accepted = 0;
   int unsigned  mismatches      = 0;
   logic         req_fire = 1'b0;
   logic         csr_fire = 1'b0;
   logic         req_gaps_on   = 1'b1;
   logic         rsp_stalls_on = 1'b1;
   int unsigned  req_gap    = 0;
   int unsigned  stall_left = 0;

   peak_hold_decay_envelope dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic bit [63:0] release_toward(input bit [63:0] x, input bit [63:0] t,
                                                input bit [63:0] keep);
      return (x * keep + t + (keep + 1) / 2) / (keep + 1);
   endfunction

   // One frame through both envelopes; updates the predicted state.
   task automatic advance_envelopes(input req_item_type f, output rsp_item_type r);
      bit [63:0]   mic;
      bit [63:0]   madd;
      bit [63:0]   tgt;
      bit [63:0]   step;
      int unsigned steps;
      int unsigned i;
      mic   = 64'(f.mic_level);
      steps = (f.ms_elapsed > DECAY_CAP) ? DECAY_CAP : 32'(f.ms_elapsed);
      if (div_q88 == 0) begin
         madd = mic;
      end else begin
         madd = (mic << 24) / (64'(div_q88) << 16);
      end
      if (madd > 64'hFF_FFFF) begin
         madd = 64'hFF_FFFF;
      end
      tgt = 64'(base_q16) + ((mic * (64'd65536 - 64'(base_q16)) * 64'(base_q16)) >> 32);
      if (tgt > 64'hFFFF) begin
         tgt = 64'hFFFF;
      end
      for (i = 0; i < steps; i++) begin
         hue_env = HUE_W'(release_toward(64'(hue_env), madd, 64'd100));
         brt_env = BRT_W'(release_toward(64'(brt_env), tgt, 64'd200));
      end
      if (madd > 64'(hue_env)) begin
         hue_env = madd[HUE_W-1:0];
      end
      if (tgt > 64'(brt_env)) begin
         brt_env = tgt[BRT_W-1:0];
      end
      step = (64'(hue_env) * 64'(f.seconds_elapsed) * 64'd100) >> 16;
      if (step > 64'hFFFF_FFFF) begin
         step = 64'hFFFF_FFFF;
      end
      r.brightness_out = brt_env;
      r.mic_level_out  = f.mic_level;
      r.hue_step       = step[STEP_W-1:0];
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Mostly short idle stretches, now and then a long one.
   function automatic int unsigned pick_idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 90);
   endfunction

   // Monitor: everything is sampled at the rising edge.
   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type pred;
      req_fire <= req_valid && !req_stall;
      csr_fire <= csr_valid && csr_ready;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (envelope_out_q.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected: %h", rsp_data));
            end else begin
               want = envelope_out_q.pop_front();
               if (rsp_data.brightness_out != want.brightness_out) begin
                  report_mismatch($sformatf("brightness_out %h, expected %h",
                                            rsp_data.brightness_out, want.brightness_out));
               end
               if (rsp_data.mic_level_out != want.mic_level_out) begin
                  report_mismatch($sformatf("mic_level_out %h, expected %h",
                                            rsp_data.mic_level_out, want.mic_level_out));
               end
               if (rsp_data.hue_step != want.hue_step) begin
                  report_mismatch($sformatf("hue_step %h, expected %h",
                                            rsp_data.hue_step, want.hue_step));
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_envelopes(req_data, pred);
            envelope_out_q.insert(envelope_out_q.size(), pred);
            frames_accepted++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SMOOTHING_DIVISOR: div_q88  = csr_wdata;
               CSR_BASE_BRIGHTNESS:   base_q16 = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Frame driver: a word holds until it is taken, then a random gap may follow.
   always @(negedge clock) begin
      if (req_valid && !req_fire) begin
         // Stalled word stays on the bus unchanged.
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap--;
      end else if (frames_to_send.size() > 0) begin
         req_valid <= 1'b1;
         req_data  <= frames_to_send.pop_front();
         if (req_gaps_on && $urandom_range(0, 99) < 30) begin
            req_gap = pick_idle_len();
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver stalls.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rsp_stalls_on && $urandom_range(0, 99) < 25) begin
         rsp_stall <= 1'b1;
         stall_left = pick_idle_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic queue_frame(input logic [MIC_W-1:0] mic, input logic [MS_W-1:0] ms,
                              input logic [SEC_W-1:0] sec);
      req_item_type f;
      f.mic_level       = mic;
      f.ms_elapsed      = ms;
      f.seconds_elapsed = sec;
      frames_to_send.insert(frames_to_send.size(), f);
      frames_queued++;
   endtask

   task automatic queue_random_frame();
      logic [MIC_W-1:0] mic;
      logic [MS_W-1:0]  ms;
      logic [SEC_W-1:0] sec;
      int unsigned      r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         mic = '0;
      end else if (r < 20) begin
         mic = '1;
      end else if (r < 50) begin
         mic = MIC_W'($urandom_range(0, 4095));
      end else begin
         mic = MIC_W'($urandom());
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
         ms = MS_W'($urandom_range(0, 8));
      end else if (r < 93) begin
         ms = MS_W'($urandom_range(9, 40));
      end else begin
         ms = MS_W'($urandom_range(200, 255));
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
         sec = SEC_W'($urandom_range(0, 32'h1_0000));
      end else if (r < 45) begin
         sec = '1;
      end else begin
         sec = SEC_W'($urandom());
      end
      queue_frame(mic, ms, sec);
   endtask

   task automatic write_csr(input csr_addr_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   // The sender pauses here until every result of the queued frames is back.
   task automatic wait_drained();
      while (frames_accepted != frames_queued || envelope_out_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_random_junk();
      csr_addr_type idx;
      idx = csr_addr_type'($urandom_range(int'(CSR_BASE_BRIGHTNESS) + 1,
                                          (1 << CSR_ADDR_W) - 1));
      write_csr(idx, CSR_DATA_W'($urandom()));
   endtask

   initial begin
      int unsigned phase;
      int unsigned n;
      logic [CSR_DATA_W-1:0] d;
      logic [CSR_DATA_W-1:0] b;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: divisor bypassed, base at one half.
      queue_frame('0, '0, '0);
      queue_frame('1, '0, '1);
      queue_frame('0, 8'd1, '1);
      queue_frame('0, 8'd255, '1);
      queue_frame(16'h8000, 8'd10, 20'h10000);
      queue_frame(16'h1234, 8'd255, 20'h80000);
      queue_frame('1, 8'd255, '0);
      queue_frame('0, 8'd37, 20'h54321);
      wait_drained();

      // Tiny divisor drives the hue level near its top and the hue step into saturation;
      // writes to unused indexes must change nothing.
      write_csr(CSR_SMOOTHING_DIVISOR, 16'h0001);
      write_csr(CSR_BASE_BRIGHTNESS, 16'hFFFF);
      write_csr({CSR_ADDR_W{1'b1}}, 16'hABCD);
      write_csr(csr_addr_type'(CSR_BASE_BRIGHTNESS + 1), 16'h1234);
      queue_frame('1, '0, '1);
      queue_frame('0, 8'd3, '1);
      queue_frame(16'h0001, '0, 20'h00001);
      queue_frame('0, 8'd255, '1);
      wait_drained();

      write_csr(CSR_SMOOTHING_DIVISOR, 16'hFFFF);
      write_csr(CSR_BASE_BRIGHTNESS, 16'h0000);
      queue_frame('1, '0, '1);
      queue_frame('0, 8'd255, '1);
      queue_frame(16'hAAAA, 8'd5, 20'h55555);
      queue_frame(16'h5555, 8'd200, 20'hAAAAA);
      wait_drained();

      write_csr(CSR_SMOOTHING_DIVISOR, 16'h0100);
      write_csr(CSR_BASE_BRIGHTNESS, 16'h0001);
      queue_frame('1, 8'd2, '1);
      queue_frame('0, 8'd8, 20'h00001);
      wait_drained();

      for (phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 4))
            0: d = '0;
            1: d = 16'h0001;
            2: d = '1;
            3: d = CSR_DATA_W'($urandom_range(1, 16'h0400));
            default: d = CSR_DATA_W'($urandom());
         endcase
         case ($urandom_range(0, 3))
            0: b = '0;
            1: b = '1;
            default: b = CSR_DATA_W'($urandom());
         endcase
         write_csr(CSR_SMOOTHING_DIVISOR, d);
         if ($urandom_range(0, 99) < 30) begin
            write_random_junk();
         end
         write_csr(CSR_BASE_BRIGHTNESS, b);
         req_gaps_on   = (phase != 2);
         rsp_stalls_on = (phase != 2) && (phase != 4);
         for (n = 0; n < 100; n++) begin
            queue_random_frame();
         end
         wait_drained();
      end

      repeat (400) @(posedge clock);
      if (mismatches == 0) begin
         $display("peak_hold_decay_envelope_tb: PASS");
      end else begin
         $display("peak_hold_decay_envelope_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("%0t ns: timed out with %0d results outstanding", $time,
               envelope_out_q.size());
      $display("peak_hold_decay_envelope_tb: FAIL");
      $finish;
   end

endmodule
